@@ src/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("check failed");
`define BPTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error("check failed");
`else
`define BPTC_ASSERT(lbl, prop)
`define BPTC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ src/bptc_pkg.sv @@
package bptc_pkg;

	localparam int RAW_WIDTH      = 24;
	localparam int TEMP_FRAC_BITS = 24;
	localparam int PIPE_DEPTH     = 14;

	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	localparam int TF_SHIFT = 48 - TEMP_FRAC_BITS;
	localparam int TP_SHIFT = TEMP_FRAC_BITS - 16;
	localparam int TF_W     = 36 + TEMP_FRAC_BITS - 24;
	localparam int TP_W     = 28;

	localparam logic [RAW_WIDTH-1:0] RAW_MASK_N = '1;
	localparam logic [23:0] RAW_MASK = 24'(RAW_MASK_N);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CALIB0 = 2'd0,
		CFG_CALIB1 = 2'd1,
		CFG_CALIB2 = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic        [15:0] t2;
		logic signed [7:0]  t3;
		logic signed [15:0] p1;
		logic signed [15:0] p2;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic        [15:0] p5;
		logic        [15:0] p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} coef_t;

	// round half up: floor((v + 2^(s-1)) / 2^s)
	function automatic logic signed [67:0] rnd_sh(input logic signed [67:0] v,
			input int unsigned s);
		logic signed [67:0] r;
		if (s == 0) begin
			r = v;
		end else begin
			r = (v + (68'sd1 <<< (s - 1))) >>> s;
		end
		return r;
	endfunction

	// exact rounding of a * r2 / 2^s from the partial products a*hi and a*lo
	function automatic logic signed [67:0] mulsh_fin(input logic signed [67:0] hi,
			input logic signed [67:0] lo, input int unsigned s);
		logic signed [67:0] acc;
		acc = hi + (lo >>> 24) + (68'sd1 <<< (s - 25));
		return acc >>> (s - 24);
	endfunction

endpackage

@@ src/bptc_calib.sv @@
module bptc_calib
	import bptc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output coef_t                coef
);

	logic [55:0] word0_q;
	logic [63:0] word1_q;
	logic [47:0] word2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word0_q <= '0;
			word1_q <= '0;
			word2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CALIB0: word0_q <= cfg_wdata[55:0];
				CFG_CALIB1: word1_q <= cfg_wdata;
				CFG_CALIB2: word2_q <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1  = word0_q[15:0];
		coef.t2  = word0_q[31:16];
		coef.t3  = $signed(word0_q[39:32]);
		coef.p1  = $signed(word0_q[55:40]);
		coef.p2  = $signed(word1_q[15:0]);
		coef.p3  = $signed(word1_q[23:16]);
		coef.p4  = $signed(word1_q[31:24]);
		coef.p5  = word1_q[47:32];
		coef.p6  = word1_q[63:48];
		coef.p7  = $signed(word2_q[7:0]);
		coef.p8  = $signed(word2_q[15:8]);
		coef.p9  = $signed(word2_q[31:16]);
		coef.p10 = $signed(word2_q[39:32]);
		coef.p11 = $signed(word2_q[47:40]);
	end

endmodule

@@ src/baro_temp_pressure_compensation.sv @@
// Barometric compensation: each request carries a raw temperature and raw pressure
// reading and yields the compensated temperature (0.01 degC, saturated to 16 bits signed),
// pressure (0.01 Pa, clamped to 0..16777215) and a flag set when either was clamped.
// The datapath is a 14-stage pipeline that takes a new request every cycle unless the
// output stalls. Each stage stalls only when it is full and the one after it cannot move,
// so bubbles close up under back-pressure. The user must write calibration words through
// the cfg port only while no request is in flight; the block does not enforce this.
`include "assert_macros.svh"

module baro_temp_pressure_compensation
	import bptc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // raw_temperature, raw_pressure
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // temperature_centi_c, pressure_centi_pa
	output logic                  m_tuser    // saturated
);

	coef_t c;

	bptc_calib u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (c)
	);

	logic [PIPE_DEPTH:1] vld_q;
	logic [PIPE_DEPTH:1] en;

	always_comb begin
		en[PIPE_DEPTH] = !vld_q[PIPE_DEPTH] || m_tready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = en[1];

	logic [23:0] rt, rp;
	assign rt = s_tdata[23:0] & RAW_MASK;
	assign rp = s_tdata[47:24] & RAW_MASK;

	logic signed [16:0] p1m;
	assign p1m = 17'(c.p1) - 17'sd16384;

	// stage registers
	logic signed [24:0]     d_s1;
	logic [23:0]            rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9, rp_s10;
	logic [47:0]            r2_s1, r2_s2, r2_s3, r2_s4, r2_s5, r2_s6;
	logic signed [32:0]     rp11_s1, rp11_s2;
	logic signed [41:0]     dt2_s2;
	logic signed [49:0]     dd_s2;
	logic signed [59:0]     s_s3;
	logic signed [57:0]     qhi_s3, qlo_s3;
	logic signed [TF_W-1:0] tf_s4;
	logic signed [TP_W-1:0] tp_s4, tp_s5, tp_s6;
	logic signed [33:0]     mq_s4, mq_s5, mq_s6, mq_s7, mq_s8;
	logic signed [55:0]     sq_s5;
	logic signed [TF_W+7:0] tf100_s5;
	logic signed [44:0]     p6tp_s5;
	logic signed [45:0]     p2tp_s5;
	logic signed [35:0]     p10tp_s5;
	logic signed [37:0]     t2_s6;
	logic signed [15:0]     tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12, tc_s13, tc_s14;
	logic                   tsat_s6, tsat_s7, tsat_s8, tsat_s9, tsat_s10, tsat_s11, tsat_s12;
	logic                   tsat_s13;
	logic signed [36:0]     l_s6;
	logic signed [38:0]     p6r_s6, p6r_s7, p6r_s8;
	logic signed [32:0]     p2r_s6, p2r_s7, p2r_s8;
	logic signed [65:0]     t2tp_s7;
	logic signed [45:0]     p7t2_s7, p3t2_s7;
	logic signed [61:0]     lhi_s7, llo_s7;
	logic signed [47:0]     t3_s8;
	logic signed [37:0]     p7r_s8, ml_s8;
	logic signed [29:0]     p3r_s8;
	logic signed [55:0]     p8t3_s9, p4t3_s9;
	logic signed [47:0]     a_s9, a_s10, a_s11;
	logic signed [35:0]     kp_s9, k_s10;
	logic signed [60:0]     rpk_s11;
	logic signed [47:0]     sum_s12;
	logic signed [55:0]     sum100_s13;
	logic [23:0]            pc_s14;
	logic                   sat_s14;

	logic signed [67:0] tcr, pcr;
	logic signed [15:0] tc_c;
	logic               tsat_c;
	logic [23:0]        pc_c;
	logic               psat_c;

	always_comb begin
		tcr = rnd_sh(tf100_s5, TEMP_FRAC_BITS);
		tsat_c = 1'b0;
		if (tcr > 68'sd32767) begin
			tc_c = 16'sh7FFF;
			tsat_c = 1'b1;
		end else if (tcr < -68'sd32768) begin
			tc_c = -16'sh8000;
			tsat_c = 1'b1;
		end else begin
			tc_c = 16'(tcr);
		end
		pcr = rnd_sh(sum100_s13, 16);
		psat_c = 1'b0;
		if (pcr < 68'sd0) begin
			pc_c = '0;
			psat_c = 1'b1;
		end else if (pcr > 68'sd16777215) begin
			pc_c = '1;
			psat_c = 1'b1;
		end else begin
			pc_c = 24'(pcr);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1    <= $signed({1'b0, rt}) - $signed({1'b0, c.t1, 8'b0});
			rp_s1   <= rp;
			r2_s1   <= rp * rp;
			rp11_s1 <= $signed({1'b0, rp}) * c.p11;
		end
		if (en[2]) begin
			dt2_s2  <= d_s1 * $signed({1'b0, c.t2});
			dd_s2   <= d_s1 * d_s1;
			rp_s2   <= rp_s1;
			r2_s2   <= r2_s1;
			rp11_s2 <= rp11_s1;
		end
		if (en[3]) begin
			s_s3   <= $signed({dt2_s2, 18'b0}) + dd_s2 * c.t3;
			qhi_s3 <= rp11_s2 * $signed({1'b0, r2_s2[47:24]});
			qlo_s3 <= rp11_s2 * $signed({1'b0, r2_s2[23:0]});
			rp_s3  <= rp_s2;
			r2_s3  <= r2_s2;
		end
		if (en[4]) begin
			tf_s4 <= TF_W'(rnd_sh(s_s3, TF_SHIFT));
			tp_s4 <= TP_W'(rnd_sh(rnd_sh(s_s3, TF_SHIFT), TP_SHIFT));
			mq_s4 <= 34'(mulsh_fin(qhi_s3, qlo_s3, 49));
			rp_s4 <= rp_s3;
			r2_s4 <= r2_s3;
		end
		if (en[5]) begin
			sq_s5    <= tp_s4 * tp_s4;
			tf100_s5 <= tf_s4 * 8'sd100;
			p6tp_s5  <= $signed({1'b0, c.p6}) * tp_s4;
			p2tp_s5  <= (c.p2 - 46'sd16384) * tp_s4;
			p10tp_s5 <= c.p10 * tp_s4;
			tp_s5    <= tp_s4;
			mq_s5    <= mq_s4;
			rp_s5    <= rp_s4;
			r2_s5    <= r2_s4;
		end
		if (en[6]) begin
			t2_s6   <= 38'(rnd_sh(sq_s5, 16));
			tc_s6   <= tc_c;
			tsat_s6 <= tsat_c;
			l_s6    <= $signed({c.p9, 16'b0}) + p10tp_s5;
			p6r_s6  <= 39'(rnd_sh(p6tp_s5, 6));
			p2r_s6  <= 33'(rnd_sh(p2tp_s5, 13));
			tp_s6   <= tp_s5;
			mq_s6   <= mq_s5;
			rp_s6   <= rp_s5;
			r2_s6   <= r2_s5;
		end
		if (en[7]) begin
			t2tp_s7 <= t2_s6 * tp_s6;
			p7t2_s7 <= c.p7 * t2_s6;
			p3t2_s7 <= c.p3 * t2_s6;
			lhi_s7  <= l_s6 * $signed({1'b0, r2_s6[47:24]});
			llo_s7  <= l_s6 * $signed({1'b0, r2_s6[23:0]});
			tc_s7   <= tc_s6;
			tsat_s7 <= tsat_s6;
			p6r_s7  <= p6r_s6;
			p2r_s7  <= p2r_s6;
			mq_s7   <= mq_s6;
			rp_s7   <= rp_s6;
		end
		if (en[8]) begin
			t3_s8   <= 48'(rnd_sh(t2tp_s7, 16));
			p7r_s8  <= 38'(rnd_sh(p7t2_s7, 8));
			p3r_s8  <= 30'(rnd_sh(p3t2_s7, 16));
			ml_s8   <= 38'(mulsh_fin(lhi_s7, llo_s7, 48));
			tc_s8   <= tc_s7;
			tsat_s8 <= tsat_s7;
			p6r_s8  <= p6r_s7;
			p2r_s8  <= p2r_s7;
			mq_s8   <= mq_s7;
			rp_s8   <= rp_s7;
		end
		if (en[9]) begin
			p8t3_s9 <= c.p8 * t3_s8;
			p4t3_s9 <= c.p4 * t3_s8;
			a_s9    <= $signed({1'b0, c.p5, 19'b0}) + p6r_s8 + p7r_s8 + ml_s8 + mq_s8;
			kp_s9   <= $signed({p1m, 12'b0}) + p2r_s8 + p3r_s8;
			tc_s9   <= tc_s8;
			tsat_s9 <= tsat_s8;
			rp_s9   <= rp_s8;
		end
		if (en[10]) begin
			k_s10    <= kp_s9 + 36'(rnd_sh(p4t3_s9, 21));
			a_s10    <= a_s9 + 48'(rnd_sh(p8t3_s9, 15));
			tc_s10   <= tc_s9;
			tsat_s10 <= tsat_s9;
			rp_s10   <= rp_s9;
		end
		if (en[11]) begin
			rpk_s11  <= $signed({1'b0, rp_s10}) * k_s10;
			a_s11    <= a_s10;
			tc_s11   <= tc_s10;
			tsat_s11 <= tsat_s10;
		end
		if (en[12]) begin
			sum_s12  <= a_s11 + 48'(rnd_sh(rpk_s11, 16));
			tc_s12   <= tc_s11;
			tsat_s12 <= tsat_s11;
		end
		if (en[13]) begin
			sum100_s13 <= sum_s12 * 8'sd100;
			tc_s13     <= tc_s12;
			tsat_s13   <= tsat_s12;
		end
		if (en[14]) begin
			pc_s14  <= pc_c;
			sat_s14 <= tsat_s13 || psat_c;
			tc_s14  <= tc_s13;
		end
	end

	assign m_tvalid = vld_q[PIPE_DEPTH];
	assign m_tdata  = {pc_s14, tc_s14};
	assign m_tuser  = sat_s14;

	`BPTC_ASSERT_IMP(a_full_stall, (&vld_q) && !m_tready, !s_tready)
	`BPTC_ASSERT_IMP(a_sat_bound, m_tvalid && m_tuser, tc_s14 == 16'sh7FFF || tc_s14 == -16'sh8000 || pc_s14 == 24'd0 || pc_s14 == 24'hFFFFFF)
	`BPTC_ASSERT_IMP(a_in_flight, $past(arst_n), $countones(vld_q) == $past($countones(vld_q)) + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready))

endmodule
